>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file slpg_checker.sv.
// Clocked on i_clk; the first form is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SLPG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Same, but also checked while reset is asserted.
`define SLPG_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/core/slpg_pkg.sv
// Package for the status LED pattern generator: pattern codes, timing
// constants, pipeline control struct and the LED level function.
// No dependencies.
`default_nettype none

package slpg_pkg;

    localparam logic [2:0] PAT_SETUP   = 3'd0;
    localparam logic [2:0] PAT_IDLE    = 3'd1;
    localparam logic [2:0] PAT_RUNNING = 3'd2;
    localparam logic [2:0] PAT_SUCCESS = 3'd3;
    localparam logic [2:0] PAT_ERROR   = 3'd4;

    localparam int unsigned SETUP_PERIOD_MS   = 1000;
    localparam int unsigned SETUP_ON_MS       = 500;
    localparam int unsigned IDLE_PERIOD_MS    = 3000;
    localparam int unsigned BLIP_MS           = 100;
    localparam int unsigned RUNNING_PERIOD_MS = 200;
    localparam int unsigned SUCCESS_HOLD_MS   = 2000;
    localparam int unsigned ERROR_SPAN_MS     = 600;

    localparam int unsigned TIME_W = 32;

    // elapsed mod 3000 = 8 * ((elapsed >> 3) mod 375) + elapsed[2:0]
    localparam int unsigned FOLD_SHIFT  = 3;
    localparam int unsigned PERIOD_FOLD = IDLE_PERIOD_MS >> FOLD_SHIFT;
    localparam int unsigned X_W         = TIME_W - FOLD_SHIFT;
    localparam int unsigned RECIP_SHIFT = 38;
    localparam int unsigned RECIP_W     = 30;
    localparam int unsigned PROD_W      = X_W + RECIP_W;
    localparam int unsigned Q_W         = PROD_W - RECIP_SHIFT;
    localparam int unsigned REM_W       = 9;
    localparam int unsigned PHASE_W     = REM_W + FOLD_SHIFT;

    localparam logic [RECIP_W-1:0] RECIP_M =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(PERIOD_FOLD) - 64'd1) / 64'(PERIOD_FOLD));

    typedef logic [2:0]         t_pat;
    typedef logic [PHASE_W-1:0] t_phase;

    typedef struct packed {
        logic vld;
        logic tick;
        t_pat pat;
    } t_ctl;

    // m is elapsed mod 3000; success and error expiry are resolved upstream.
    function automatic logic led_level(t_pat pat, t_phase m);
        logic odd;
        logic lit;
        odd = 1'b0;
        for (int k = 1; k < int'(IDLE_PERIOD_MS / BLIP_MS); k++) begin
            odd = odd ^ (m >= PHASE_W'(k * (RUNNING_PERIOD_MS / 2)));
        end
        case (pat)
            PAT_SETUP: begin
                lit = (m < PHASE_W'(SETUP_ON_MS)) ||
                      (m >= PHASE_W'(SETUP_PERIOD_MS) &&
                       m < PHASE_W'(SETUP_PERIOD_MS + SETUP_ON_MS)) ||
                      (m >= PHASE_W'(2 * SETUP_PERIOD_MS) &&
                       m < PHASE_W'(2 * SETUP_PERIOD_MS + SETUP_ON_MS));
            end
            PAT_IDLE:    lit = (m < PHASE_W'(BLIP_MS));
            PAT_RUNNING: lit = !odd;
            PAT_SUCCESS: lit = 1'b1;
            PAT_ERROR:   lit = !odd;
            default:     lit = 1'b0;
        endcase
        return lit;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/slpg_phase.sv
// Two-stage elapsed-time reduction to the 3000 ms phase (reciprocal
// multiply, then remainder). Depends on slpg_pkg.
`default_nettype none

module slpg_phase (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire slpg_pkg::t_ctl                i_ctl,
    input  wire logic [slpg_pkg::TIME_W-1:0]   i_elapsed,
    output slpg_pkg::t_ctl                     o_ctl,
    output slpg_pkg::t_phase                   o_phase
);
    import slpg_pkg::*;

    logic [X_W-1:0]        x;
    logic [PROD_W-1:0]     prod;
    logic [X_W-1:0]        rem_full;

    t_ctl                  r_a_ctl;
    logic [Q_W-1:0]        r_a_q;
    logic [X_W-1:0]        r_a_x;
    logic [FOLD_SHIFT-1:0] r_a_low;
    t_ctl                  r_b_ctl;
    t_phase                r_b_phase;

    assign x        = i_elapsed[TIME_W-1:FOLD_SHIFT];
    assign prod     = PROD_W'(x) * PROD_W'(RECIP_M);
    assign rem_full = r_a_x - X_W'(r_a_q) * X_W'(PERIOD_FOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
        end else if (i_en) begin
            r_a_ctl <= i_ctl;
            r_b_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_q     <= prod[PROD_W-1:RECIP_SHIFT];
            r_a_x     <= x;
            r_a_low   <= i_elapsed[FOLD_SHIFT-1:0];
            r_b_phase <= {rem_full[REM_W-1:0], r_a_low};
        end
    end

    assign o_ctl   = r_b_ctl;
    assign o_phase = r_b_phase;

endmodule

`default_nettype wire

>>> rtl/core/status_led_pattern_generator.sv
// Status LED pattern generator. Accepts one word per cycle while the output is
// not stalled and returns one result word per input word, in order. The pattern
// state (anchor, expiry into idle) updates in a single stage, which sets the
// one-word-per-cycle rate; the phase within the 3000 ms cycle is then found by
// a reciprocal multiply and remainder over two stages. A stalled output holds
// the whole pipeline. Depends on slpg_pkg and slpg_phase.
`default_nettype none

module status_led_pattern_generator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_mode,
    input  wire logic [31:0]                   i_now_ms,
    input  wire logic [2:0]                    i_new_state,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_led_on,
    output logic [2:0]                         o_pattern_state
);
    import slpg_pkg::*;

    logic                 en;
    logic [TIME_W-1:0]    anchor;
    logic [TIME_W-1:0]    elapsed;
    logic                 expire;
    t_ctl                 s1_ctl;
    t_ctl                 ph_ctl;
    t_phase               ph_phase;

    logic                 r_s0_vld;
    logic                 r_s0_mode;
    logic [TIME_W-1:0]    r_s0_now;
    t_pat                 r_s0_ns;

    t_pat                 r_pattern, n_pattern;
    logic [TIME_W-1:0]    r_entry, n_entry;
    logic                 r_anchored, n_anchored;

    t_ctl                 r_s1_ctl;
    logic [TIME_W-1:0]    r_s1_elapsed;

    logic                 r_out_vld;
    logic                 r_led;
    t_pat                 r_out_pat;

    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_s0_mode <= i_mode;
            r_s0_now  <= i_now_ms;
            r_s0_ns   <= i_new_state;
        end
    end

    always_comb begin
        n_pattern  = r_pattern;
        n_entry    = r_entry;
        n_anchored = r_anchored;
        anchor     = r_anchored ? r_entry : r_s0_now;
        elapsed    = r_s0_now - anchor;
        expire     = 1'b0;
        if (r_s0_mode) begin
            if (r_s0_ns inside {[PAT_SETUP:PAT_ERROR]}) begin
                n_pattern  = r_s0_ns;
                n_entry    = '0;
                n_anchored = 1'b0;
            end
        end else begin
            n_entry    = anchor;
            n_anchored = 1'b1;
            expire = (r_pattern == PAT_SUCCESS && elapsed >= TIME_W'(SUCCESS_HOLD_MS)) ||
                     (r_pattern == PAT_ERROR && elapsed >= TIME_W'(ERROR_SPAN_MS));
            if (expire) begin
                n_pattern = PAT_IDLE;
                n_entry   = r_s0_now;
                elapsed   = '0;
            end
        end
        s1_ctl.vld  = r_s0_vld;
        s1_ctl.tick = !r_s0_mode;
        s1_ctl.pat  = n_pattern;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern  <= PAT_SETUP;
            r_entry    <= '0;
            r_anchored <= 1'b0;
            r_s1_ctl   <= '0;
        end else if (en) begin
            r_s1_ctl <= s1_ctl;
            if (r_s0_vld) begin
                r_pattern  <= n_pattern;
                r_entry    <= n_entry;
                r_anchored <= n_anchored;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_elapsed <= elapsed;
        end
    end

    slpg_phase u_phase (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_ctl     (r_s1_ctl),
        .i_elapsed (r_s1_elapsed),
        .o_ctl     (ph_ctl),
        .o_phase   (ph_phase)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_led     <= 1'b0;
        end else if (en) begin
            r_out_vld <= ph_ctl.vld;
            if (ph_ctl.vld && ph_ctl.tick) begin
                r_led <= led_level(ph_ctl.pat, ph_phase);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && ph_ctl.vld) begin
            r_out_pat <= ph_ctl.pat;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_led_on        = r_led;
    assign o_pattern_state = r_out_pat;

endmodule

`default_nettype wire

>>> rtl/core/slpg_checker.sv
// Port-level checks for status_led_pattern_generator, bound to the top level.
// Depends on slpg_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module slpg_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_ready,
    input  wire logic        o_valid,
    input  wire logic        i_ready,
    input  wire logic        o_led_on,
    input  wire logic [2:0]  o_pattern_state
);
    import slpg_pkg::*;

    `SLPG_ASSERT_RST(a_rst_clears, !i_rst_n |=> !o_valid, "output valid after reset")
    `SLPG_ASSERT(a_hold, o_valid && !i_ready |=> o_valid && $stable(o_led_on) && $stable(o_pattern_state), "stalled word changed")
    `SLPG_ASSERT(a_flow, (!o_valid || i_ready) |-> o_ready, "input blocked with free output")
    `SLPG_ASSERT(a_state_code, o_valid |-> (o_pattern_state <= PAT_ERROR), "bad pattern state")

endmodule

bind status_led_pattern_generator slpg_checker u_slpg_checker (.*);

`default_nettype wire

>>> test/status_led_pattern_generator_checker.sv
// Checker for the status LED pattern generator: tracks the pattern, anchor and
// LED level for every accepted input word and compares each result word in order.
// Depends on slpg_pkg for pattern codes and timing constants.
module status_led_pattern_generator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_set_state,
    input  logic [31:0] i_now_ms,
    input  logic [2:0]  i_new_state,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_led_on,
    input  logic [2:0]  i_pattern_state,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import slpg_pkg::*;

    typedef struct packed {
        logic lit;
        t_pat pat;
    } led_status_t;

    led_status_t status_due[$];
    t_pat        cur_pat;
    logic [31:0] anchor_ms;
    logic        anchored;
    logic        lamp;
    int          failures;
    int          checked;

    function automatic logic lamp_level(t_pat pat, logic [31:0] t);
        case (pat)
            PAT_SETUP:   return (t % SETUP_PERIOD_MS) < SETUP_ON_MS;
            PAT_IDLE:    return (t % IDLE_PERIOD_MS) < BLIP_MS;
            PAT_RUNNING: return (t % RUNNING_PERIOD_MS) < BLIP_MS;
            PAT_SUCCESS: return t < SUCCESS_HOLD_MS;
            PAT_ERROR:   return (t < ERROR_SPAN_MS) && (((t / BLIP_MS) % 2) == 0);
            default:     return 1'b0;
        endcase
    endfunction

    task automatic take_word(input logic set_state, input logic [31:0] now, input t_pat code);
        logic [31:0] elapsed;
        if (set_state) begin
            // unknown codes leave everything as it was
            if (code <= PAT_ERROR) begin
                cur_pat   = code;
                anchor_ms = '0;
                anchored  = 1'b0;
            end
        end else begin
            if (!anchored) begin
                anchor_ms = now;
                anchored  = 1'b1;
            end
            elapsed = now - anchor_ms;
            if ((cur_pat == PAT_SUCCESS && elapsed >= SUCCESS_HOLD_MS) ||
                (cur_pat == PAT_ERROR && elapsed >= ERROR_SPAN_MS)) begin
                cur_pat   = PAT_IDLE;
                anchor_ms = now;
                elapsed   = '0;
            end
            lamp = lamp_level(cur_pat, elapsed);
        end
        status_due.push_back('{lit: lamp, pat: cur_pat});
    endtask

    initial begin
        failures = 0;
        checked  = 0;
    end

    always @(posedge i_clk) begin
        led_status_t want;
        logic        bad;
        if (!i_rst_n) begin
            cur_pat   = PAT_SETUP;
            anchor_ms = '0;
            anchored  = 1'b0;
            lamp      = 1'b0;
            status_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (status_due.size() == 0) begin
                    $display("%0t: unexpected word led_on %0b pattern_state %0d",
                             $time, i_led_on, i_pattern_state);
                    failures++;
                end else begin
                    want = status_due.pop_front();
                    bad  = 1'b0;
                    if (i_led_on !== want.lit) begin
                        $display("%0t: led_on expected %0b actual %0b",
                                 $time, want.lit, i_led_on);
                        bad = 1'b1;
                    end
                    if (i_pattern_state !== want.pat) begin
                        $display("%0t: pattern_state expected %0d actual %0d",
                                 $time, want.pat, i_pattern_state);
                        bad = 1'b1;
                    end
                    if (bad) failures++;
                    checked++;
                end
            end
            if (i_in_valid && i_in_ready) take_word(i_set_state, i_now_ms, i_new_state);
        end
        o_fail_count <= failures;
        o_pending    <= status_due.size();
        o_checked    <= checked;
    end

endmodule

>>> test/status_led_pattern_generator_tb.sv
// Top of the status LED pattern generator testbench: clock, reset, stimulus
// and verdict. Directed words first, then bursts of random pattern sequences.
// Depends on slpg_pkg, the block and status_led_pattern_generator_checker.
module status_led_pattern_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import slpg_pkg::*;

    localparam logic MODE_TICK       = 1'b0;
    localparam logic MODE_SET        = 1'b1;
    localparam t_pat LAST_CODE       = '1;
    localparam int   RANDOM_WORDS    = 800;
    localparam int   HOLD_OFF_CYCLES = 300;
    localparam int   DRAIN_CYCLES    = 16;
    localparam int   CYCLE_LIMIT     = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        in_mode;
    logic [31:0] now_ms;
    t_pat        new_state;
    logic        out_valid;
    logic        out_ready;
    logic        led_on;
    t_pat        pattern_state;

    int          fail_count;
    int          pending;
    int          checked;
    int          ticks_sent;
    int          commands_sent;
    int          unknown_sent;
    int          cycle_count;
    logic [31:0] wall_ms;
    bit          hold_off_req;
    bit          hold_off_done;

    status_led_pattern_generator dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_ready         (in_ready),
        .i_mode          (in_mode),
        .i_now_ms        (now_ms),
        .i_new_state     (new_state),
        .o_valid         (out_valid),
        .i_ready         (out_ready),
        .o_led_on        (led_on),
        .o_pattern_state (pattern_state)
    );

    status_led_pattern_generator_checker slpg_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_set_state     (in_mode == MODE_SET),
        .i_now_ms        (now_ms),
        .i_new_state     (new_state),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_led_on        (led_on),
        .i_pattern_state (pattern_state),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending);
        $display("status_led_pattern_generator_tb failed");
        $finish;
    end

    task automatic send_word(input logic mode, input logic [31:0] stamp, input t_pat code);
        in_valid  <= 1'b1;
        in_mode   <= mode;
        now_ms    <= stamp;
        new_state <= code;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (mode == MODE_TICK) ticks_sent++;
        else if (code > PAT_ERROR) unknown_sent++;
        else commands_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // receiver: segments of always ready, coin flip, mostly stalled and periodic
    initial begin
        int style;
        int seg_len;
        int beat;
        out_ready <= 1'b0;
        beat = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end else begin
                style   = $urandom_range(0, 3);
                seg_len = $urandom_range(8, 64);
                repeat (seg_len) begin
                    case (style)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= $urandom_range(0, 1);
                        2:       out_ready <= ($urandom_range(0, 3) == 0);
                        default: out_ready <= (beat % 4 != 0);
                    endcase
                    beat++;
                    @(posedge clk);
                end
            end
        end
    end

    initial begin
        int  burst_len;
        int  gap;
        int  kind;
        int  step;
        int  random_sent;
        bit  paused_once;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        in_mode       <= MODE_TICK;
        now_ms        <= '0;
        new_state     <= PAT_SETUP;
        wall_ms       = '0;
        hold_off_req  = 1'b0;
        hold_off_done = 1'b0;
        ticks_sent    = 0;
        commands_sent = 0;
        unknown_sent  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // setup pattern straight out of reset
        send_word(MODE_TICK, 32'd0, PAT_SETUP);
        send_word(MODE_TICK, 32'd499, LAST_CODE);
        send_word(MODE_TICK, 32'd500, PAT_SETUP);
        // success hold near the top of the timestamp range, then expiry into idle across the wrap
        send_word(MODE_SET, 32'hFFFF_FFFF, PAT_SUCCESS);
        send_word(MODE_TICK, 32'hFFFF_F800, PAT_SETUP);
        send_word(MODE_TICK, 32'hFFFF_FFCF, PAT_SETUP);
        send_word(MODE_TICK, 32'hFFFF_FFD0, PAT_SETUP);
        send_word(MODE_TICK, 32'h0000_0034, PAT_SETUP);
        // error pulses and expiry
        send_word(MODE_SET, 32'd0, PAT_ERROR);
        send_word(MODE_TICK, 32'd5000, PAT_SETUP);
        send_word(MODE_TICK, 32'd5200, PAT_SETUP);
        send_word(MODE_TICK, 32'd5599, PAT_SETUP);
        send_word(MODE_TICK, 32'd5600, PAT_SETUP);
        // running anchored at the top of the range
        send_word(MODE_SET, 32'd0, PAT_RUNNING);
        send_word(MODE_TICK, 32'hFFFF_FFFF, PAT_SETUP);
        send_word(MODE_TICK, 32'd99, PAT_SETUP);
        send_word(MODE_TICK, 32'd199, PAT_SETUP);
        // unknown codes are dropped
        send_word(MODE_SET, 32'd0, PAT_ERROR + 3'd1);
        send_word(MODE_SET, 32'd0, LAST_CODE);
        // same state twice re-anchors
        send_word(MODE_SET, 32'd0, PAT_IDLE);
        send_word(MODE_SET, 32'd0, PAT_IDLE);
        send_word(MODE_TICK, 32'h7FFF_FFFF, PAT_SETUP);
        send_word(MODE_TICK, 32'h8000_0BB7, PAT_SETUP);
        send_word(MODE_SET, 32'd0, PAT_SETUP);
        send_word(MODE_TICK, 32'hAAAA_AAAA, PAT_SETUP);
        wait_drained();

        random_sent = 0;
        paused_once = 1'b0;
        while (random_sent < RANDOM_WORDS) begin
            burst_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 16);
            repeat (burst_len) begin
                kind = $urandom_range(0, 99);
                if (kind < 7) begin
                    send_word(MODE_SET, $urandom, t_pat'($urandom_range(PAT_SETUP, PAT_ERROR)));
                    random_sent++;
                end else if (kind < 9) begin
                    send_word(MODE_SET, $urandom,
                              t_pat'($urandom_range(PAT_ERROR + 1, LAST_CODE)));
                end else begin
                    step = $urandom_range(0, 99);
                    if (step < 70) wall_ms += $urandom_range(0, 150);
                    else if (step < 85) wall_ms += $urandom_range(150, 3500);
                    else if (step < 90) wall_ms = $urandom;
                    else if (step < 95) wall_ms -= $urandom_range(1, 500);
                    else wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
                    send_word(MODE_TICK, wall_ms, t_pat'($urandom));
                    random_sent++;
                end
            end
            if (random_sent >= 150) hold_off_req = 1'b1;
            if (!paused_once && random_sent >= RANDOM_WORDS / 2) begin
                paused_once = 1'b1;
                wait_drained();
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d ticks, %0d pattern commands and %0d unknown codes",
                 ticks_sent, commands_sent, unknown_sent);
        $display("%0d result words compared, with a long output stall and a full drain",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("status_led_pattern_generator_tb passed");
        end else begin
            $display("status_led_pattern_generator_tb failed");
        end
        $finish;
    end

endmodule
